### rtl/vfcm_pkg.sv
package vfcm_pkg;

  // voxel classes
  typedef enum logic [1:0] {
    CLASS_AIR    = 2'd0,
    CLASS_OPAQUE = 2'd1,
    CLASS_PLANT  = 2'd2,
    CLASS_LIQUID = 2'd3
  } vox_class_t;

  // mesh codes on mesh_select
  localparam logic [1:0] MESH_OPAQUE = 2'd0;
  localparam logic [1:0] MESH_PLANT  = 2'd1;
  localparam logic [1:0] MESH_WATER  = 2'd2;

  // face order: back, front, left, right, top, bottom
  localparam int NUM_FACES = 6;
  localparam logic [2:0] FACE_TOP = 3'd4;

  localparam int COUNT_W     = 20;
  localparam int POS_W       = 15;
  localparam int TEX_W       = 8;
  localparam int QUEUE_DEPTH = 4;

  // corner code raise/lower marks for water
  localparam logic [2:0] WATER_RAISED  = 3'd4;
  localparam logic [2:0] WATER_LOWERED = 3'd5;

  // one classified voxel waiting for the quad emitter
  typedef struct packed {
    logic [POS_W-1:0]           pos_word;
    logic [1:0]                 cls;
    logic [NUM_FACES-1:0]       face_mask;
    logic                       liquid_above;
    logic [NUM_FACES*TEX_W-1:0] textures;
    logic                       chunk_start;
  } desc_t;

  localparam logic [4:0] SOLID_CORNER [0:5][0:3] = '{
    '{5'h02, 5'h07, 5'h14, 5'h11},
    '{5'h0F, 5'h1C, 5'h19, 5'h0A},
    '{5'h03, 5'h10, 5'h1D, 5'h0E},
    '{5'h06, 5'h0B, 5'h18, 5'h15},
    '{5'h10, 5'h15, 5'h1A, 5'h1F},
    '{5'h03, 5'h0E, 5'h09, 5'h04}
  };

  localparam logic [4:0] LIQUID_CORNER [0:5][0:3] = '{
    '{5'h02, 5'h07, 5'h14, 5'h11},
    '{5'h0F, 5'h1C, 5'h19, 5'h0A},
    '{5'h03, 5'h11, 5'h1C, 5'h0E},
    '{5'h06, 5'h0B, 5'h18, 5'h15},
    '{5'h10, 5'h15, 5'h1A, 5'h1F},
    '{5'h03, 5'h0E, 5'h09, 5'h04}
  };

  // bit k set: corner k is a top corner of the face
  localparam logic [3:0] LIQUID_TOP_MASK [0:5] = '{
    4'hC, 4'h6, 4'h6, 4'hC, 4'hF, 4'h0
  };

  localparam logic [4:0] PLANT_CORNER [0:1][0:3] = '{
    '{5'h10, 5'h19, 5'h0A, 5'h03},
    '{5'h14, 5'h1D, 5'h0E, 5'h07}
  };

  // corner byte of one vertex
  function automatic logic [7:0] corner_word(
    input logic [1:0] cls,
    input logic [2:0] face,
    input logic [1:0] corner,
    input logic       liquid_above
  );
    logic [3:0] top_mask;
    logic [2:0] mark;
    top_mask = LIQUID_TOP_MASK[face];
    if (top_mask[corner] && (face == FACE_TOP || !liquid_above)) begin
      mark = WATER_RAISED;
    end else begin
      mark = WATER_LOWERED;
    end
    case (cls)
      CLASS_PLANT:  corner_word = {3'b000, PLANT_CORNER[face[0]][corner]};
      CLASS_LIQUID: corner_word = {mark, LIQUID_CORNER[face][corner]};
      default:      corner_word = {3'b000, SOLID_CORNER[face][corner]};
    endcase
  endfunction

endpackage

### rtl/voxel_face_cull_mesher.sv
// Voxel face-culling mesher.
// Input channel: one voxel per beat, taken at a rising edge with push high and
// full low. Output channel: one quad per beat; the oldest quad sits on the
// result ports while empty is low and leaves at an edge with pop high.
// A voxel gives zero to six quads: two for a plant, one per visible face for
// opaque or liquid, none for air. last marks the final quad of a voxel.
// A pushed voxel passes the queue slot and the emitter's descriptor register
// before its first quad reaches the output register. Throughput: the quad
// emitter makes one quad per cycle while the output is empty or popped; a voxel
// holds it until done, and the next voxel loads in the cycle of its last quad.
// The front classifies voxels into a small queue (QUEUE_DEPTH entries), so
// input keeps flowing while the emitter works or the receiver stalls; with
// pop low the result ports hold, the queue fills and full rises.
// Reset (rst, synchronous) empties the queue and output stage and clears the
// three vertex counters. chunk_start on a voxel, air included, clears all
// counters before that voxel's quads.
module voxel_face_cull_mesher #(
  parameter int QUEUE_DEPTH = vfcm_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic [3:0]  pos_z,
  input  logic [1:0]  block_class,
  input  logic [11:0] neighbor_classes,
  input  logic        above_outside,
  input  logic [47:0] face_textures,
  input  logic        chunk_start,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  mesh_select,
  output logic [19:0] quad_base_index,
  output logic [31:0] vertex_0,
  output logic [31:0] vertex_1,
  output logic [31:0] vertex_2,
  output logic [31:0] vertex_3,
  output logic        last
);
  import vfcm_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t             front_desc;
  desc_t             head_desc;
  logic              q_empty;
  logic              q_pop;
  logic [CNT_W-1:0]  q_count;

  // classify
  vfcm_front u_front (
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .pos_z            (pos_z),
    .block_class      (block_class),
    .neighbor_classes (neighbor_classes),
    .above_outside    (above_outside),
    .face_textures    (face_textures),
    .chunk_start      (chunk_start),
    .desc             (front_desc)
  );

  // decoupling queue
  vfcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_desc),
    .pop   (q_pop),
    .dout  (head_desc),
    .full  (full),
    .empty (q_empty),
    .count (q_count)
  );

  // quad emitter
  vfcm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .desc            (head_desc),
    .desc_valid      (!q_empty),
    .desc_pop        (q_pop),
    .empty           (empty),
    .pop             (pop),
    .mesh_select     (mesh_select),
    .quad_base_index (quad_base_index),
    .vertex_0        (vertex_0),
    .vertex_1        (vertex_1),
    .vertex_2        (vertex_2),
    .vertex_3        (vertex_3),
    .last            (last)
  );

  // checks
  a_base_aligned: assert property (@(posedge clk) disable iff (rst)
    !empty |-> quad_base_index[1:0] == 2'b00)
    else $error("quad base index not a multiple of four");

  a_mesh_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (mesh_select == MESH_OPAQUE || mesh_select == MESH_PLANT ||
                mesh_select == MESH_WATER))
    else $error("bad mesh code");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_water_marks: assert property (@(posedge clk) disable iff (rst)
    (!empty && mesh_select == MESH_WATER) |->
      ((vertex_0[31:29] == WATER_RAISED || vertex_0[31:29] == WATER_LOWERED) &&
       !vertex_0[15]))
    else $error("water corner mark out of range");

endmodule

### rtl/vfcm_front.sv
module vfcm_front (
  input  logic [3:0]            pos_x,
  input  logic [6:0]            pos_y,
  input  logic [3:0]            pos_z,
  input  logic [1:0]            block_class,
  input  logic [11:0]           neighbor_classes,
  input  logic                  above_outside,
  input  logic [47:0]           face_textures,
  input  logic                  chunk_start,
  output vfcm_pkg::desc_t       desc
);
  import vfcm_pkg::*;

  logic [NUM_FACES-1:0] visible;
  logic                 liquid_above;

  // a face shows when the neighbor class differs from our own
  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      visible[f] = (neighbor_classes[2*f +: 2] != block_class);
    end
    liquid_above = above_outside || (neighbor_classes[9:8] == CLASS_LIQUID);
  end

  // build the descriptor for the emitter
  always_comb begin
    desc.pos_word     = {pos_y, pos_z, pos_x};
    desc.cls          = block_class;
    desc.liquid_above = liquid_above;
    desc.textures     = face_textures;
    desc.chunk_start  = chunk_start;
    case (block_class)
      CLASS_PLANT: desc.face_mask = 6'b000011;
      CLASS_AIR:   desc.face_mask = '0;
      default:     desc.face_mask = visible;
    endcase
  end

endmodule

### rtl/vfcm_queue.sv
module vfcm_queue #(
  parameter int DEPTH = vfcm_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  vfcm_pkg::desc_t          din,
  input  logic                     pop,
  output vfcm_pkg::desc_t          dout,
  output logic                     full,
  output logic                     empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import vfcm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  desc_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/vfcm_back.sv
module vfcm_back (
  input  logic            clk,
  input  logic            rst,
  input  vfcm_pkg::desc_t desc,
  input  logic            desc_valid,
  output logic            desc_pop,
  output logic            empty,
  input  logic            pop,
  output logic [1:0]      mesh_select,
  output logic [19:0]     quad_base_index,
  output logic [31:0]     vertex_0,
  output logic [31:0]     vertex_1,
  output logic [31:0]     vertex_2,
  output logic [31:0]     vertex_3,
  output logic            last
);
  import vfcm_pkg::*;

  desc_t                cur;
  logic                 active;
  logic [NUM_FACES-1:0] remain;
  logic                 out_valid;

  logic [COUNT_W-1:0]   opaque_count;
  logic [COUNT_W-1:0]   plant_count;
  logic [COUNT_W-1:0]   water_count;

  logic [2:0]           sel_face;
  logic [NUM_FACES-1:0] sel_bit;
  logic                 is_last;
  logic                 emit;
  logic                 load;
  logic [1:0]           mesh;
  logic [COUNT_W-1:0]   base;
  logic [TEX_W-1:0]     tex;
  logic [31:0]          vtx [4];

  // lowest pending face first
  always_comb begin
    sel_face = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (remain[f]) begin
        sel_face = 3'(f);
      end
    end
    sel_bit = NUM_FACES'(1) << sel_face;
    is_last = ((remain & ~sel_bit) == '0);
  end

  assign emit     = active && (!out_valid || pop);
  assign load     = desc_valid && (!active || (emit && is_last));
  assign desc_pop = load;
  assign empty    = !out_valid;

  // mesh, counter and texture of the current quad
  always_comb begin
    case (cur.cls)
      CLASS_PLANT: begin
        mesh = MESH_PLANT;
        base = plant_count;
      end
      CLASS_LIQUID: begin
        mesh = MESH_WATER;
        base = water_count;
      end
      default: begin
        mesh = MESH_OPAQUE;
        base = opaque_count;
      end
    endcase
    tex = cur.textures[TEX_W-1:0];
    if (cur.cls != CLASS_PLANT) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        if (sel_face == 3'(f)) begin
          tex = cur.textures[TEX_W*f +: TEX_W];
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      vtx[i] = {corner_word(cur.cls, sel_face, 2'(i), cur.liquid_above),
                tex, 1'b0, cur.pos_word};
    end
  end

  // descriptor walk
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= (desc.face_mask != '0);
    end else if (emit && is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur    <= desc;
      remain <= desc.face_mask;
    end else if (emit) begin
      remain <= remain & ~sel_bit;
    end
  end

  // vertex counters; a chunk start clears all three
  always_ff @(posedge clk) begin
    if (rst) begin
      opaque_count <= '0;
      plant_count  <= '0;
      water_count  <= '0;
    end else if (load && desc.chunk_start) begin
      opaque_count <= '0;
      plant_count  <= '0;
      water_count  <= '0;
    end else if (emit) begin
      case (mesh)
        MESH_PLANT: plant_count  <= plant_count + COUNT_W'(4);
        MESH_WATER: water_count  <= water_count + COUNT_W'(4);
        default:    opaque_count <= opaque_count + COUNT_W'(4);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mesh_select     <= mesh;
      quad_base_index <= base;
      vertex_0        <= vtx[0];
      vertex_1        <= vtx[1];
      vertex_2        <= vtx[2];
      vertex_3        <= vtx[3];
      last            <= is_last;
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import vfcm_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 248;

  // receiver stall segment kinds
  localparam int RX_FLOW     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;
  localparam int RX_HOLD     = 3;

  // corner codes per face (back, front, left, right, top, bottom) and corner
  localparam logic [0:5][0:3][4:0] SOLID_TAB = {
    5'h02, 5'h07, 5'h14, 5'h11,
    5'h0F, 5'h1C, 5'h19, 5'h0A,
    5'h03, 5'h10, 5'h1D, 5'h0E,
    5'h06, 5'h0B, 5'h18, 5'h15,
    5'h10, 5'h15, 5'h1A, 5'h1F,
    5'h03, 5'h0E, 5'h09, 5'h04
  };
  localparam logic [0:5][0:3][4:0] LIQUID_TAB = {
    5'h02, 5'h07, 5'h14, 5'h11,
    5'h0F, 5'h1C, 5'h19, 5'h0A,
    5'h03, 5'h11, 5'h1C, 5'h0E,
    5'h06, 5'h0B, 5'h18, 5'h15,
    5'h10, 5'h15, 5'h1A, 5'h1F,
    5'h03, 5'h0E, 5'h09, 5'h04
  };
  localparam logic [0:1][0:3][4:0] PLANT_TAB = {
    5'h10, 5'h19, 5'h0A, 5'h03,
    5'h14, 5'h1D, 5'h0E, 5'h07
  };
  // bit k set: corner k sits at the top of a liquid face
  localparam logic [0:5][3:0] TOP_CORNERS = {4'hC, 4'h6, 4'h6, 4'hC, 4'hF, 4'h0};

  typedef struct packed {
    logic [1:0]        mesh;
    logic [19:0]       base;
    logic [3:0][31:0]  vtx;
    logic              last;
  } quad_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [3:0]  pos_x;
  logic [6:0]  pos_y;
  logic [3:0]  pos_z;
  logic [1:0]  block_class;
  logic [11:0] neighbor_classes;
  logic        above_outside;
  logic [47:0] face_textures;
  logic        chunk_start;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  mesh_select;
  logic [19:0] quad_base_index;
  logic [31:0] vertex_0;
  logic [31:0] vertex_1;
  logic [31:0] vertex_2;
  logic [31:0] vertex_3;
  logic        last;

  // predicted mesh state and quads still to come
  logic [COUNT_W-1:0] opaque_next_vertex;
  logic [COUNT_W-1:0] plant_next_vertex;
  logic [COUNT_W-1:0] water_next_vertex;
  quad_t              pending_quads [$];

  int err_count   = 0;
  int cycle_count = 0;
  bit tx_gaps_on  = 1'b1;
  bit rx_free     = 1'b0;
  int burst_left  = 0;
  int rx_left     = 0;
  int rx_kind     = RX_FLOW;
  int rx_tick     = 0;

  voxel_face_cull_mesher dut (.*);

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // expected quads for one accepted voxel
  task automatic mesh_voxel(
    input logic [3:0]  x,
    input logic [6:0]  y,
    input logic [3:0]  z,
    input vox_class_t  cls,
    input logic [11:0] nb,
    input logic        above,
    input logic [47:0] tex,
    input logic        cs
  );
    quad_t      batch [6];
    int         n;
    logic [14:0] posw;
    logic       liq_above;
    logic [1:0] ncls;
    logic [7:0] t;
    logic [2:0] mark;
    logic [7:0] corner;
    n = 0;
    posw = {y, z, x};
    if (cs) begin
      opaque_next_vertex = '0;
      plant_next_vertex  = '0;
      water_next_vertex  = '0;
    end
    case (cls) inside
      CLASS_PLANT: begin
        // two crossed quads, back texture, neighbours ignored
        for (int f = 0; f < 2; f++) begin
          batch[n].mesh = MESH_PLANT;
          batch[n].base = plant_next_vertex;
          batch[n].last = 1'b0;
          for (int i = 0; i < 4; i++)
            batch[n].vtx[i] = {3'b000, PLANT_TAB[f][i], tex[7:0], 1'b0, posw};
          plant_next_vertex = plant_next_vertex + COUNT_W'(4);
          n++;
        end
      end
      CLASS_OPAQUE, CLASS_LIQUID: begin
        liq_above = above || (nb[9:8] == CLASS_LIQUID);
        // one quad per face whose neighbour has another class
        for (int f = 0; f < 6; f++) begin
          ncls = nb[2*f +: 2];
          if (ncls != cls) begin
            t = tex[8*f +: 8];
            for (int i = 0; i < 4; i++) begin
              if (cls == CLASS_OPAQUE) begin
                corner = {3'b000, SOLID_TAB[f][i]};
              end else begin
                mark = (TOP_CORNERS[f][i] && (f == FACE_TOP || !liq_above)) ?
                       WATER_RAISED : WATER_LOWERED;
                corner = {mark, LIQUID_TAB[f][i]};
              end
              batch[n].vtx[i] = {corner, t, 1'b0, posw};
            end
            batch[n].last = 1'b0;
            if (cls == CLASS_OPAQUE) begin
              batch[n].mesh = MESH_OPAQUE;
              batch[n].base = opaque_next_vertex;
              opaque_next_vertex = opaque_next_vertex + COUNT_W'(4);
            end else begin
              batch[n].mesh = MESH_WATER;
              batch[n].base = water_next_vertex;
              water_next_vertex = water_next_vertex + COUNT_W'(4);
            end
            n++;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) batch[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_quads.insert(pending_quads.size(), batch[k]);
  endtask

  // one voxel beat, with burst gaps between groups of beats
  task automatic send_voxel(
    input logic [3:0]  x,
    input logic [6:0]  y,
    input logic [3:0]  z,
    input vox_class_t  cls,
    input logic [11:0] nb,
    input logic        above,
    input logic [47:0] tex,
    input logic        cs
  );
    int gap;
    if (tx_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    pos_x            <= x;
    pos_y            <= y;
    pos_z            <= z;
    block_class      <= cls;
    neighbor_classes <= nb;
    above_outside    <= above;
    face_textures    <= tex;
    chunk_start      <= cs;
    push             <= 1'b1;
    do @(posedge clk); while (full);
    mesh_voxel(x, y, z, cls, nb, above, tex, cs);
  endtask

  task automatic hold_input();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_quads.size() != 0) @(posedge clk);
  endtask

  // random voxel, neighbours biased toward the own class so faces get culled
  task automatic send_random_voxel();
    vox_class_t  cls;
    logic [11:0] nb;
    int          r;
    r = $urandom_range(0, 99);
    cls = (r < 15) ? CLASS_AIR : (r < 50) ? CLASS_OPAQUE :
          (r < 70) ? CLASS_PLANT : CLASS_LIQUID;
    for (int f = 0; f < 6; f++)
      nb[2*f +: 2] = $urandom_range(0, 1) ? cls : 2'($urandom_range(0, 3));
    send_voxel(4'($urandom), 7'($urandom), 4'($urandom), cls, nb,
               $urandom_range(0, 3) == 0, {16'($urandom), 32'($urandom)},
               $urandom_range(0, 24) == 0);
  endtask

  task automatic test_opaque_faces();
    // all six faces at the extreme position, then at the origin
    send_voxel(4'hF, 7'h7F, 4'hF, CLASS_OPAQUE, 12'h000, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_voxel(4'h0, 7'h00, 4'h0, CLASS_OPAQUE, 12'h000, 1'b1, 48'h0, 1'b0);
    // interior voxel gives nothing
    send_voxel(4'h5, 7'h40, 4'h9, CLASS_OPAQUE, 12'h555, 1'b0, 48'h1234_5678_9ABC, 1'b0);
    send_voxel(4'h3, 7'h0A, 4'hC, CLASS_OPAQUE,
               {CLASS_LIQUID, CLASS_PLANT, CLASS_OPAQUE, CLASS_AIR, CLASS_OPAQUE,
                CLASS_LIQUID}, 1'b0, 48'hA5A5_5A5A_C33C, 1'b0);
    send_voxel(4'hF, 7'h00, 4'h0, CLASS_OPAQUE, 12'hAAA, 1'b0, 48'h0123_4567_89AB, 1'b0);
  endtask

  task automatic test_plant_quads();
    send_voxel(4'h7, 7'h64, 4'h2, CLASS_PLANT, 12'hAAA, 1'b1, 48'hFFFF_FFFF_FF5A, 1'b0);
    send_voxel(4'hF, 7'h7F, 4'hF, CLASS_PLANT, 12'h000, 1'b0, 48'h0000_0000_00FF, 1'b0);
    send_voxel(4'h0, 7'h00, 4'h0, CLASS_PLANT, 12'hFFF, 1'b1, 48'hFFFF_FFFF_FF00, 1'b0);
  endtask

  task automatic test_liquid_surface();
    // open surface: sides raised, top face raised
    send_voxel(4'h4, 7'h3C, 4'h4, CLASS_LIQUID, 12'h000, 1'b0, 48'h1122_3344_5566, 1'b0);
    // liquid above: sides lowered, top culled
    send_voxel(4'h4, 7'h3B, 4'h4, CLASS_LIQUID,
               {CLASS_AIR, CLASS_LIQUID, CLASS_AIR, CLASS_AIR, CLASS_AIR, CLASS_AIR},
               1'b0, 48'h6655_4433_2211, 1'b0);
    // above the chunk counts as liquid above, top face still drawn
    send_voxel(4'h8, 7'h7F, 4'h1, CLASS_LIQUID, 12'h000, 1'b1, 48'hF0E1_D2C3_B4A5, 1'b0);
    send_voxel(4'h2, 7'h7F, 4'hE, CLASS_LIQUID,
               {CLASS_LIQUID, CLASS_AIR, CLASS_LIQUID, CLASS_LIQUID, CLASS_LIQUID,
                CLASS_LIQUID}, 1'b1, 48'h0F1E_2D3C_4B5A, 1'b0);
    // surrounded by liquid
    send_voxel(4'h9, 7'h20, 4'h9, CLASS_LIQUID, 12'hFFF, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_voxel(4'hA, 7'h21, 4'h6, CLASS_LIQUID,
               {CLASS_OPAQUE, CLASS_AIR, CLASS_PLANT, CLASS_OPAQUE, CLASS_PLANT,
                CLASS_AIR}, 1'b0, 48'h8040_2010_0804, 1'b0);
    send_voxel(4'hF, 7'h7F, 4'hF, CLASS_LIQUID, 12'h000, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
  endtask

  task automatic test_air_and_chunk_start();
    send_voxel(4'hF, 7'h7F, 4'hF, CLASS_AIR, 12'hFFF, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0);
    // air still clears the counters
    send_voxel(4'h0, 7'h00, 4'h0, CLASS_AIR, 12'h000, 1'b0, 48'h0, 1'b1);
    send_voxel(4'h1, 7'h01, 4'h1, CLASS_OPAQUE, 12'h000, 1'b0, 48'h0102_0304_0506, 1'b0);
    send_voxel(4'h6, 7'h55, 4'h3, CLASS_LIQUID, 12'h000, 1'b0, 48'hDEAD_BEEF_CAFE, 1'b1);
    send_voxel(4'hC, 7'h2A, 4'hB, CLASS_PLANT, 12'h555, 1'b0, 48'h0000_0000_0077, 1'b1);
  endtask

  // sender stops until every quad is out, then resumes
  task automatic test_idle_restart();
    repeat (6) send_random_voxel();
    hold_input();
    wait_drained();
    repeat (6) send_random_voxel();
  endtask

  task automatic test_random_voxels();
    int  sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // rotate sender and receiver behavior every quarter
      case ((sent * 4) / RANDOM_ITEMS)
        0: begin tx_gaps_on = 1'b1; rx_free = 1'b0; end
        1: begin tx_gaps_on = 1'b0; rx_free = 1'b1; end
        2: begin tx_gaps_on = 1'b1; rx_free = 1'b1; end
        default: begin tx_gaps_on = 1'b0; rx_free = 1'b0; end
      endcase
      send_random_voxel();
      sent++;
    end
    tx_gaps_on = 1'b1;
    rx_free    = 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_free) begin
      pop <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_kind = $urandom_range(RX_FLOW, RX_HOLD);
        rx_left = (rx_kind == RX_HOLD) ? $urandom_range(1, 8) : $urandom_range(4, 24);
      end
      rx_left--;
      rx_tick++;
      case (rx_kind)
        RX_FLOW:     pop <= 1'b1;
        RX_RANDOM:   pop <= ($urandom_range(0, 99) >= 40);
        RX_PERIODIC: pop <= (rx_tick % 3) != 0;
        default:     pop <= 1'b0;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  // compare each quad beat with the oldest prediction
  always @(posedge clk) begin : check_quads
    quad_t want;
    if (!rst && pop && !empty) begin
      if (pending_quads.size() == 0) begin
        err_count++;
        $error("unexpected quad: mesh %0d base %h", mesh_select, quad_base_index);
      end else begin
        want = pending_quads.pop_front();
        check_field("mesh_select", 32'(want.mesh), 32'(mesh_select));
        check_field("quad_base_index", 32'(want.base), 32'(quad_base_index));
        check_field("vertex_0", want.vtx[0], vertex_0);
        check_field("vertex_1", want.vtx[1], vertex_1);
        check_field("vertex_2", want.vtx[2], vertex_2);
        check_field("vertex_3", want.vtx[3], vertex_3);
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  initial begin
    rst              = 1'b1;
    push             = 1'b0;
    pos_x            = '0;
    pos_y            = '0;
    pos_z            = '0;
    block_class      = CLASS_AIR;
    neighbor_classes = '0;
    above_outside    = 1'b0;
    face_textures    = '0;
    chunk_start      = 1'b0;
    opaque_next_vertex = '0;
    plant_next_vertex  = '0;
    water_next_vertex  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_opaque_faces();
    test_plant_quads();
    test_liquid_surface();
    test_air_and_chunk_start();
    test_idle_restart();
    test_random_voxels();

    // drain and watch for stray quads
    hold_input();
    rx_free = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### voxel_face_cull_mesher.f
rtl/vfcm_pkg.sv
rtl/vfcm_front.sv
rtl/vfcm_queue.sv
rtl/vfcm_back.sv
rtl/voxel_face_cull_mesher.sv
dv/testbench.sv
